>>> src/nvr_pkg.sv
// nvr_pkg: shared types, widths and constants of the nv21 to rgb normalizer
// no dependencies
package nvr_pkg;

  localparam int Y_W      = 8;
  localparam int DIFF_W   = 9;
  localparam int C14_W    = 25;
  localparam int PROD_W   = 42;
  localparam int SUM_W    = PROD_W + 1;
  localparam int OUT_W    = 24;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CH   = 3;
  localparam int NUM_PIX  = 4;
  localparam int POS_W    = 2;
  localparam int OUT_SHIFT = 18;

  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  // q2.14 color coefficients
  localparam logic signed [15:0] COEF_RV = 16'sd22938;
  localparam logic signed [15:0] COEF_GU = 16'sd5571;
  localparam logic signed [15:0] COEF_GV = 16'sd11633;
  localparam logic signed [15:0] COEF_BU = 16'sd29000;

  localparam logic signed [DIFF_W-1:0] CHROMA_BIAS = 9'sd128;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'sd1 <<< (OUT_SHIFT - 1));
  localparam logic signed [C14_W-1:0] OUT_MAX = 25'sd8388607;
  localparam logic signed [C14_W-1:0] OUT_MIN = -25'sd8388608;

  localparam logic [CFG_W-1:0] MEAN_RESET  = 16'd0;
  localparam logic [CFG_W-1:0] SCALE_RESET = 16'd4096;

  localparam logic [POS_W-1:0] POS_LAST = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_MEAN    = 3'd0,
    REG_GREEN_MEAN  = 3'd1,
    REG_BLUE_MEAN   = 3'd2,
    REG_RED_SCALE   = 3'd3,
    REG_GREEN_SCALE = 3'd4,
    REG_BLUE_SCALE  = 3'd5
  } cfg_reg_e;

  typedef logic signed [C14_W-1:0] c14_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic [Y_W-1:0]    y;
    logic [DIFF_W-1:0] dv;
    logic [DIFF_W-1:0] du;
    tag_t              tag;
  } pix_t;

  typedef struct packed {
    logic [NUM_CH-1:0][CFG_W-1:0] mean;
    logic [NUM_CH-1:0][CFG_W-1:0] scale;
  } cfg_t;

endpackage

>>> src/nvr_serial.sv
// nvr_serial: holds one 2x2 group and emits its four pixels one per cycle while adv_i is high
// depends on nvr_pkg
module nvr_serial (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [nvr_pkg::Y_W-1:0] luma_top_left_i,
  input  logic [nvr_pkg::Y_W-1:0] luma_top_right_i,
  input  logic [nvr_pkg::Y_W-1:0] luma_bottom_left_i,
  input  logic [nvr_pkg::Y_W-1:0] luma_bottom_right_i,
  input  logic [nvr_pkg::Y_W-1:0] chroma_v_i,
  input  logic [nvr_pkg::Y_W-1:0] chroma_u_i,
  output logic                   pix_valid_o,
  output nvr_pkg::pix_t          pix_o
);
  import nvr_pkg::*;

  logic                  busy_q, busy_d;
  logic [POS_W-1:0]      cnt_q, cnt_d;
  logic [Y_W-1:0]        luma_q [NUM_PIX];
  logic [DIFF_W-1:0]     dv_q, du_q;
  logic                  load;
  logic                  step;

  assign step       = adv_i && busy_q;
  assign in_ready_o = !busy_q || (step && (cnt_q == POS_LAST));
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (step) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == POS_LAST) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      luma_q[0] <= luma_top_left_i;
      luma_q[1] <= luma_top_right_i;
      luma_q[2] <= luma_bottom_left_i;
      luma_q[3] <= luma_bottom_right_i;
      dv_q      <= $signed({1'b0, chroma_v_i}) - CHROMA_BIAS;
      du_q      <= $signed({1'b0, chroma_u_i}) - CHROMA_BIAS;
    end
  end

  always_comb begin
    pix_valid_o  = busy_q;
    pix_o.y      = luma_q[cnt_q];
    pix_o.dv     = dv_q;
    pix_o.du     = du_q;
    pix_o.tag.pos  = cnt_q;
    pix_o.tag.last = (cnt_q == POS_LAST);
  end

endmodule

>>> src/nvr_csc.sv
// nvr_csc: two-stage color conversion of one pixel to q.14 rgb
// depends on nvr_pkg
module nvr_csc (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           pix_valid_i,
  input  nvr_pkg::pix_t  pix_i,
  output logic           c14_valid_o,
  output nvr_pkg::tag_t  tag_o,
  output nvr_pkg::c14_t  c14_o [nvr_pkg::NUM_CH]
);
  import nvr_pkg::*;

  logic           s1_vld_q, s2_vld_q;
  tag_t           s1_tag_q, s2_tag_q;
  logic [Y_W-1:0] s1_y_q;
  c14_t           s1_off_q [NUM_CH];
  c14_t           s1_off_d [NUM_CH];
  c14_t           s2_c14_q [NUM_CH];
  c14_t           y14;
  logic signed [DIFF_W-1:0] dv, du;

  // chroma offsets, constant multiplies on 9-bit differences
  always_comb begin
    dv = $signed(pix_i.dv);
    du = $signed(pix_i.du);
    s1_off_d[CH_R] = C14_W'(COEF_RV) * C14_W'(dv);
    s1_off_d[CH_G] = c14_t'(0) - C14_W'(COEF_GU) * C14_W'(du) - C14_W'(COEF_GV) * C14_W'(dv);
    s1_off_d[CH_B] = C14_W'(COEF_BU) * C14_W'(du);
  end

  assign y14 = $signed({3'b000, s1_y_q, 14'd0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= pix_valid_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_y_q   <= pix_i.y;
      s1_tag_q <= pix_i.tag;
      s2_tag_q <= s1_tag_q;
      for (int k = 0; k < NUM_CH; k++) begin
        s1_off_q[k] <= s1_off_d[k];
        s2_c14_q[k] <= y14 + s1_off_q[k];
      end
    end
  end

  assign c14_valid_o = s2_vld_q;
  assign tag_o       = s2_tag_q;
  assign c14_o       = s2_c14_q;

endmodule

>>> src/nvr_norm.sv
// nvr_norm: mean subtract, scale multiply, round and saturate, three stages
// depends on nvr_pkg; the last stage is the block's output register
module nvr_norm (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  nvr_pkg::cfg_t            cfg_i,
  input  logic                     c14_valid_i,
  input  nvr_pkg::tag_t            tag_i,
  input  nvr_pkg::c14_t            c14_i [nvr_pkg::NUM_CH],
  output logic                     out_valid_o,
  output nvr_pkg::tag_t            tag_o,
  output logic [nvr_pkg::OUT_W-1:0] rgb_o [nvr_pkg::NUM_CH]
);
  import nvr_pkg::*;

  logic                     s3_vld_q, s4_vld_q, s5_vld_q;
  tag_t                     s3_tag_q, s4_tag_q, s5_tag_q;
  c14_t                     s3_d_q   [NUM_CH];
  logic signed [PROD_W-1:0] s4_p_q   [NUM_CH];
  logic [OUT_W-1:0]         s5_out_q [NUM_CH];
  logic [OUT_W-1:0]         s5_out_d [NUM_CH];

  // round half up, arithmetic shift is floor, then clamp
  always_comb begin
    logic signed [SUM_W-1:0] rsum;
    logic signed [SUM_W-1:0] rsh;
    logic signed [C14_W-1:0] r;
    for (int k = 0; k < NUM_CH; k++) begin
      rsum = SUM_W'(s4_p_q[k]) + RND_HALF;
      rsh  = rsum >>> OUT_SHIFT;
      r    = $signed(rsh[C14_W-1:0]);
      if (r > OUT_MAX) begin
        s5_out_d[k] = OUT_MAX[OUT_W-1:0];
      end else if (r < OUT_MIN) begin
        s5_out_d[k] = OUT_MIN[OUT_W-1:0];
      end else begin
        s5_out_d[k] = r[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (adv_i) begin
      s3_vld_q <= c14_valid_i;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_tag_q <= tag_i;
      s4_tag_q <= s3_tag_q;
      s5_tag_q <= s4_tag_q;
      for (int k = 0; k < NUM_CH; k++) begin
        s3_d_q[k]   <= c14_i[k] - $signed({3'b000, cfg_i.mean[k], 6'd0});
        s4_p_q[k]   <= PROD_W'(s3_d_q[k]) * $signed(PROD_W'(cfg_i.scale[k]));
        s5_out_q[k] <= s5_out_d[k];
      end
    end
  end

  assign out_valid_o = s5_vld_q;
  assign tag_o       = s5_tag_q;
  assign rgb_o       = s5_out_q;

endmodule

>>> src/nv21_to_rgb_normalize.sv
// nv21_to_rgb_normalize: nv21 2x2 group to four normalized rgb pixels
// depends on nvr_pkg, nvr_serial, nvr_csc, nvr_norm
// path: a group enters the group register, then each pixel runs through stages 1 to 5
// throughput: one pixel per cycle while the sink takes them, set by the
// single result channel that the group serializer feeds
// reset: clears all valid bits and the pixel counter, means to 0, scales to 4096
module nv21_to_rgb_normalize (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nvr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nvr_pkg::CFG_W-1:0]        cfg_data_i,
  // group input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [nvr_pkg::Y_W-1:0]          luma_top_left_i,
  input  logic [nvr_pkg::Y_W-1:0]          luma_top_right_i,
  input  logic [nvr_pkg::Y_W-1:0]          luma_bottom_left_i,
  input  logic [nvr_pkg::Y_W-1:0]          luma_bottom_right_i,
  input  logic [nvr_pkg::Y_W-1:0]          chroma_v_i,
  input  logic [nvr_pkg::Y_W-1:0]          chroma_u_i,
  // pixel output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [nvr_pkg::OUT_W-1:0] red_out_o,
  output logic signed [nvr_pkg::OUT_W-1:0] green_out_o,
  output logic signed [nvr_pkg::OUT_W-1:0] blue_out_o,
  output logic [nvr_pkg::POS_W-1:0]        pixel_position_o,
  output logic                             group_end_o
);
  import nvr_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             adv;
  logic             pix_valid;
  pix_t             pix;
  logic             c14_valid;
  tag_t             c14_tag;
  c14_t             c14 [NUM_CH];
  tag_t             out_tag;
  logic [OUT_W-1:0] rgb [NUM_CH];

  // the whole pipeline moves as one: it only holds while a finished pixel
  // sits in the output register and the sink is not taking it
  assign adv = !out_valid_o || out_ready_i;

  // configuration registers, always writable; writes beyond the list drop
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RED_MEAN:    cfg_d.mean[CH_R]  = cfg_data_i;
        REG_GREEN_MEAN:  cfg_d.mean[CH_G]  = cfg_data_i;
        REG_BLUE_MEAN:   cfg_d.mean[CH_B]  = cfg_data_i;
        REG_RED_SCALE:   cfg_d.scale[CH_R] = cfg_data_i;
        REG_GREEN_SCALE: cfg_d.scale[CH_G] = cfg_data_i;
        REG_BLUE_SCALE:  cfg_d.scale[CH_B] = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CH; k++) begin
        cfg_q.mean[k]  <= MEAN_RESET;
        cfg_q.scale[k] <= SCALE_RESET;
      end
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // group register and pixel counter
  nvr_serial u_serial (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .adv_i               (adv),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .luma_top_left_i     (luma_top_left_i),
    .luma_top_right_i    (luma_top_right_i),
    .luma_bottom_left_i  (luma_bottom_left_i),
    .luma_bottom_right_i (luma_bottom_right_i),
    .chroma_v_i          (chroma_v_i),
    .chroma_u_i          (chroma_u_i),
    .pix_valid_o         (pix_valid),
    .pix_o               (pix)
  );

  // stages 1-2: chroma offsets, then luma add
  nvr_csc u_csc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .pix_valid_i (pix_valid),
    .pix_i       (pix),
    .c14_valid_o (c14_valid),
    .tag_o       (c14_tag),
    .c14_o       (c14)
  );

  // stages 3-5: mean, scale multiply, round and clamp into the output register
  nvr_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cfg_i       (cfg_q),
    .c14_valid_i (c14_valid),
    .tag_i       (c14_tag),
    .c14_i       (c14),
    .out_valid_o (out_valid_o),
    .tag_o       (out_tag),
    .rgb_o       (rgb)
  );

  assign red_out_o        = $signed(rgb[CH_R]);
  assign green_out_o      = $signed(rgb[CH_G]);
  assign blue_out_o       = $signed(rgb[CH_B]);
  assign pixel_position_o = out_tag.pos;
  assign group_end_o      = out_tag.last;

endmodule

>>> src/nvr_check.sv
// nvr_check: port-level checks of the nv21 to rgb normalizer, bound to the top
// depends on nvr_pkg and nv21_to_rgb_normalize
module nvr_check (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [nvr_pkg::OUT_W-1:0] red_out_o,
  input logic signed [nvr_pkg::OUT_W-1:0] green_out_o,
  input logic signed [nvr_pkg::OUT_W-1:0] blue_out_o,
  input logic [nvr_pkg::POS_W-1:0]        pixel_position_o,
  input logic                             group_end_o
);
  import nvr_pkg::*;

  // a stalled pixel holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o) &&
      $stable(green_out_o) && $stable(blue_out_o) && $stable(pixel_position_o) &&
      $stable(group_end_o))
    else $error("stalled output pixel changed");

  // end marker only on the bottom-right pixel
  a_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> group_end_o == (pixel_position_o == POS_LAST))
    else $error("group end marker does not match pixel position");

  // pixels of one group are presented in consecutive cycles, in order
  a_pos_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (pixel_position_o != POS_LAST) |=>
      out_valid_o && (pixel_position_o == POS_W'($past(pixel_position_o) + 2'd1)))
    else $error("pixel order broken within a group");

  // a freshly taken group blocks the input while it is serialized
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a group was taken");

endmodule

bind nv21_to_rgb_normalize nvr_check u_nvr_check (.*);
